// ===== rtl/cmha_pkg.sv =====
`timescale 1ns / 1ps

package cmha_pkg;

    localparam int DIR_W   = 16;
    localparam int KIND_W  = 2;
    localparam int WGT_W   = 16;
    localparam int CELL_W  = 4;
    localparam int CNT_W   = 32;
    localparam int GRID_W  = 5;
    localparam int CFG_W   = 5;
    localparam int CFG_IDX_W = 1;

    // |component| fits 17 bits, so does 2m
    localparam int MAG_W   = DIR_W + 1;
    // quotient never exceeds the grid size, which fits the register width
    localparam int QUO_W   = GRID_W;
    // numerator times grid size
    localparam int NUM_W   = MAG_W + GRID_W;

    localparam logic [KIND_W-1:0] KIND_OCCUPIED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THREE_D_MODE = 1'd1;

    localparam logic [GRID_W-1:0] GRID_SIZE_RST = 5'd16;

    typedef struct packed {
        logic signed [DIR_W-1:0] dir_x;
        logic signed [DIR_W-1:0] dir_y;
        logic signed [DIR_W-1:0] dir_z;
        logic [KIND_W-1:0]       obs_kind;
        logic [WGT_W-1:0]        obs_weight;
    } t_cmha_in;

    typedef struct packed {
        logic              skipped;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic [CELL_W-1:0] cell_z;
        logic [CNT_W-1:0]  hit_total;
        logic [CNT_W-1:0]  miss_total;
    } t_cmha_out;

endpackage

// ===== rtl/cmha_in_if.sv =====
`timescale 1ns / 1ps

interface cmha_in_if import cmha_pkg::*; ();
    logic     valid;
    logic     ready;
    t_cmha_in payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/cmha_out_if.sv =====
`timescale 1ns / 1ps

interface cmha_out_if import cmha_pkg::*; ();
    logic      valid;
    logic      ready;
    t_cmha_out payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/cube_map_hit_miss_accumulator.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Signals                          Transaction
// i_in      in   valid ready payload(t_cmha_in)   valid & ready at rising edge
// o_out     out  valid ready payload(t_cmha_out)  valid & ready at rising edge
// cfg       in   i_cfg_we i_cfg_idx i_cfg_data    write when i_cfg_we is high
//
// An item passes through the steps magnitude, multiply, a three-lane radix-2
// divider, counter read and write-back; a zero vector skips from magnitude to
// write-back. A new item is accepted only after the previous one is written back.
// After reset a clearing pass writes all MAX_GRID**3 counters before
// i_in.ready rises; configuration writes are taken anytime.
// The result sits in an output register, so a stalled o_out only holds the
// write-back until that register frees.

module cube_map_hit_miss_accumulator import cmha_pkg::*; #(
    parameter int MAX_GRID = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    cmha_in_if.sink              i_in,
    cmha_out_if.source           o_out
);

    localparam int CELLS = MAX_GRID * MAX_GRID * MAX_GRID;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(MAX_GRID);
    localparam int LANES = 3;
    localparam logic [AW-1:0] ROW_STEP   = AW'(MAX_GRID);
    localparam logic [AW-1:0] PLANE_STEP = AW'(MAX_GRID * MAX_GRID);
    localparam logic [AW-1:0] LAST_ADDR  = AW'(CELLS - 1);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_MAG  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_ADR  = 3'd5;
    localparam logic [2:0] S_WB   = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [AW-1:0] r_clr_addr;

    logic [GRID_W-1:0] r_grid_size;
    logic              r_three_d;
    logic [GRID_W-1:0] w_res;

    logic signed [DIR_W-1:0] r_bx, r_by, r_bz;
    logic [KIND_W-1:0]       r_kind;
    logic [WGT_W-1:0]        r_weight;
    logic                    r_skip;

    logic [MAG_W-1:0] w_ax, w_ay, w_az, w_m;
    logic [MAG_W:0]   w_sx, w_sy, w_sz;
    logic             w_zero;

    logic [MAG_W-1:0] r_num [LANES];
    logic [MAG_W-1:0] r_den;
    logic [NUM_W-1:0] r_rem [LANES];
    logic [NUM_W-1:0] r_dsh;
    logic [QUO_W-1:0] r_quo [LANES];
    logic [2:0]       r_cnt;

    logic [QUO_W-1:0] w_qc [LANES];
    logic [CW-1:0]    w_cell [LANES];
    logic [CW-1:0]    r_cell [LANES];
    logic [AW-1:0]    w_addr, r_addr;

    logic [CNT_W-1:0] hit_mem  [CELLS];
    logic [CNT_W-1:0] miss_mem [CELLS];
    logic [CNT_W-1:0] r_hit_rd, r_miss_rd;
    logic [CNT_W:0]   w_hit_sum, w_miss_sum;
    logic [CNT_W-1:0] w_hit_new, w_miss_new;
    logic             w_hit_upd, w_miss_upd;
    logic             w_hit_we, w_miss_we;
    logic [AW-1:0]    w_waddr;
    logic [CNT_W-1:0] w_hit_wd, w_miss_wd;

    logic      r_out_valid;
    t_cmha_out r_out;
    logic      w_out_free;
    logic      w_wb_go;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_size <= GRID_SIZE_RST;
            r_three_d   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_SIZE:    r_grid_size <= i_cfg_data;
                CFG_THREE_D_MODE: r_three_d   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_grid_size < GRID_W'(2)) begin
            w_res = GRID_W'(2);
        end else if (32'(r_grid_size) > MAX_GRID) begin
            w_res = GRID_W'(MAX_GRID);
        end else begin
            w_res = r_grid_size;
        end
    end

    // magnitude stage
    always_comb begin
        w_ax = r_bx[DIR_W-1] ? (MAG_W'(0) - {1'b1, r_bx}) : {1'b0, r_bx};
        w_ay = r_by[DIR_W-1] ? (MAG_W'(0) - {1'b1, r_by}) : {1'b0, r_by};
        w_az = r_bz[DIR_W-1] ? (MAG_W'(0) - {1'b1, r_bz}) : {1'b0, r_bz};
        w_m  = w_ax;
        if (w_ay > w_m) begin
            w_m = w_ay;
        end
        if (w_az > w_m) begin
            w_m = w_az;
        end
        w_zero = (w_m == '0);
        // b + m lies in 0..2m, so the low bits carry it exactly
        w_sx = {{2{r_bx[DIR_W-1]}}, r_bx} + {1'b0, w_m};
        w_sy = {{2{r_by[DIR_W-1]}}, r_by} + {1'b0, w_m};
        w_sz = {{2{r_bz[DIR_W-1]}}, r_bz} + {1'b0, w_m};
    end

    // clamp and cell address
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            w_qc[i]   = (r_quo[i] >= w_res) ? (w_res - GRID_W'(1)) : r_quo[i];
            w_cell[i] = CW'(w_qc[i]);
        end
        w_addr = AW'(w_cell[0]) + AW'(w_cell[1]) * ROW_STEP + AW'(w_cell[2]) * PLANE_STEP;
    end

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_wb_go    = (r_state == S_WB) && w_out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:  if (r_clr_addr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE: if (i_in.valid) n_state = S_MAG;
            S_MAG:  n_state = w_zero ? S_WB : S_MUL;
            S_MUL:  n_state = S_DIV;
            S_DIV:  if (r_cnt == 3'(QUO_W - 1)) n_state = S_ADR;
            S_ADR:  n_state = S_WB;
            S_WB:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr_addr <= '0;
            r_cnt      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
            if (r_state == S_DIV) begin
                r_cnt <= r_cnt + 3'd1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_bx     <= i_in.payload.dir_x;
            r_by     <= i_in.payload.dir_y;
            r_bz     <= i_in.payload.dir_z;
            r_kind   <= i_in.payload.obs_kind;
            r_weight <= i_in.payload.obs_weight;
        end
        if (r_state == S_MAG) begin
            r_skip   <= w_zero;
            r_den    <= MAG_W'({w_m, 1'b0});
            r_num[0] <= w_sx[MAG_W-1:0];
            r_num[1] <= w_sy[MAG_W-1:0];
            if (r_three_d) begin
                r_num[2] <= w_sz[MAG_W-1:0];
            end else if (!r_bz[DIR_W-1]) begin
                r_num[2] <= {1'b0, r_bz};
            end else begin
                // negative z floors below zero and clamps to cell 0
                r_num[2] <= '0;
            end
        end
        if (r_state == S_MUL) begin
            for (int i = 0; i < LANES; i++) begin
                r_rem[i] <= NUM_W'(r_num[i]) * NUM_W'(w_res);
                r_quo[i] <= '0;
            end
            r_dsh <= NUM_W'(r_den) << (QUO_W - 1);
        end
        if (r_state == S_DIV) begin
            for (int i = 0; i < LANES; i++) begin
                if (r_rem[i] >= r_dsh) begin
                    r_rem[i] <= r_rem[i] - r_dsh;
                    r_quo[i] <= {r_quo[i][QUO_W-2:0], 1'b1};
                end else begin
                    r_quo[i] <= {r_quo[i][QUO_W-2:0], 1'b0};
                end
            end
            r_dsh <= r_dsh >> 1;
        end
        if (r_state == S_ADR) begin
            r_addr <= w_addr;
            for (int i = 0; i < LANES; i++) begin
                r_cell[i] <= w_cell[i];
            end
        end
    end

    // counter update
    assign w_hit_sum  = {1'b0, r_hit_rd} + (CNT_W + 1)'(r_weight);
    assign w_miss_sum = {1'b0, r_miss_rd} + (CNT_W + 1)'(r_weight);
    assign w_miss_upd = (r_kind == KIND_OCCUPIED) || (r_kind == KIND_EMPTY);
    assign w_hit_upd  = (r_kind == KIND_UNKNOWN);
    assign w_hit_new  = !w_hit_upd ? r_hit_rd
                      : (w_hit_sum[CNT_W] ? '1 : w_hit_sum[CNT_W-1:0]);
    assign w_miss_new = !w_miss_upd ? r_miss_rd
                      : (w_miss_sum[CNT_W] ? '1 : w_miss_sum[CNT_W-1:0]);

    assign w_hit_we  = (r_state == S_CLR) || (w_wb_go && !r_skip && w_hit_upd);
    assign w_miss_we = (r_state == S_CLR) || (w_wb_go && !r_skip && w_miss_upd);
    assign w_waddr   = (r_state == S_CLR) ? r_clr_addr : r_addr;
    assign w_hit_wd  = (r_state == S_CLR) ? '0 : w_hit_new;
    assign w_miss_wd = (r_state == S_CLR) ? '0 : w_miss_new;

    always_ff @(posedge i_clk) begin
        if (w_hit_we) begin
            hit_mem[w_waddr] <= w_hit_wd;
        end
        if (r_state == S_ADR) begin
            r_hit_rd <= hit_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_miss_we) begin
            miss_mem[w_waddr] <= w_miss_wd;
        end
        if (r_state == S_ADR) begin
            r_miss_rd <= miss_mem[w_addr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_wb_go) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wb_go) begin
            if (r_skip) begin
                r_out <= '{skipped: 1'b1, default: '0};
            end else begin
                r_out.skipped    <= 1'b0;
                r_out.cell_x     <= CELL_W'(r_cell[0]);
                r_out.cell_y     <= CELL_W'(r_cell[1]);
                r_out.cell_z     <= CELL_W'(r_cell[2]);
                r_out.hit_total  <= w_hit_new;
                r_out.miss_total <= w_miss_new;
            end
        end
    end

    assign i_in.ready    = (r_state == S_IDLE);
    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.payload.skipped) |->
            (o_out.payload.hit_total == '0 && o_out.payload.miss_total == '0
             && o_out.payload.cell_x == '0 && o_out.payload.cell_z == '0))
        else $error("skipped result carries nonzero fields");

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hit_we || w_miss_we) |-> (r_state == S_CLR || r_state == S_WB))
        else $error("counter write outside clear or write-back");

    a_accept_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_MAG))
        else $error("accepted transaction did not start processing");

    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (!r_out_valid && !i_in.ready))
        else $error("activity during clearing pass");

endmodule
